/* src/mmm_pkg.sv */
`timescale 1ns / 1ps

package mmm_pkg;

   // command and result formats
   localparam int CMD_W       = 16;
   localparam int MIN_W       = 13;
   localparam int MIX_W       = 33;
   localparam int IDX_W       = 3;
   localparam int ONE_Q12     = 4096;

   // rotor count limits
   localparam int MAX_ROTORS     = 7;
   localparam int NUM_ROTORS_DEF = 4;
   localparam int MIX_REGS       = 4;
   localparam int MIX_SEL_W      = 2;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 33;

   localparam logic [CSR_IDX_W-1:0] REG_SPD_FLOOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROTOR0_MIX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROTOR3_MIX = 3'd4;

   // internal datapath widths
   localparam int WW   = 22;          // mixed speed, signed Q.12
   localparam int KW   = 13;          // magnitude of 1.0 - min speed
   localparam int QW   = 13;          // rescale quotient bits
   localparam int DW   = 22;          // divisor (twice the span)
   localparam int RW   = 38;          // dividend and partial remainder
   localparam int PA_W = WW - 1 + KW; // offset times rescale numerator

   typedef struct packed {
      logic signed [CMD_W-1:0] thr;
      logic signed [WW-1:0]    w;
      logic [IDX_W-1:0]        idx;
      logic                    last;
      logic                    rescale;
      logic                    zero_span;
      logic                    k_neg;
   } rot_tag_type;

endpackage

/* src/mmm_req_if.sv */
`timescale 1ns / 1ps

interface mmm_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [mmm_pkg::CMD_W-1:0] thrust_cmd;
   logic signed [mmm_pkg::CMD_W-1:0] roll_cmd;
   logic signed [mmm_pkg::CMD_W-1:0] pitch_cmd;
   logic signed [mmm_pkg::CMD_W-1:0] yaw_cmd;

   modport source (output valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
   modport sink (input valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

/* src/mmm_rsp_if.sv */
`timescale 1ns / 1ps

interface mmm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mmm_pkg::IDX_W-1:0]        rotor_index;
   logic signed [mmm_pkg::CMD_W-1:0] speed_out;
   logic                             last_rotor;

   modport source (output valid, rotor_index, speed_out, last_rotor, input ready);
   modport sink (input valid, rotor_index, speed_out, last_rotor, output ready);
endinterface

/* src/mmm_div.sv */
`timescale 1ns / 1ps

module mmm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [mmm_pkg::RW-1:0]    in_num,
   input  logic [mmm_pkg::DW-1:0]    in_den,
   input  mmm_pkg::rot_tag_type      in_tag,
   output logic                      out_valid,
   output logic [mmm_pkg::QW-1:0]    out_quo,
   output mmm_pkg::rot_tag_type      out_tag
);
   import mmm_pkg::*;

   logic              vld_ff [QW];
   logic [QW-1:0]     q_ff   [QW];
   rot_tag_type       tag_ff [QW];
   logic [RW-1:0]     rem_ff [QW-1];
   logic [DW-1:0]     den_ff [QW-1];

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [RW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] q_src;
      logic [QW-1:0] q_in;
      rot_tag_type   tag_src;
      logic          vld_src;
      logic [RW-1:0] sub;
      logic          fits;

      if (s == 0) begin : g_first
         assign rem_src = in_num;
         assign den_src = in_den;
         assign q_src   = '0;
         assign tag_src = in_tag;
         assign vld_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign tag_src = tag_ff[s-1];
         assign vld_src = vld_ff[s-1];
      end

      assign sub  = RW'(den_src) << (QW - 1 - s);
      assign fits = rem_src >= sub;

      always_comb begin
         q_in = q_src;
         q_in[QW-1-s] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[s]   <= q_in;
            tag_ff[s] <= tag_src;
         end
      end

      if (s < QW - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= fits ? rem_src - sub : rem_src;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = q_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

/* src/multirotor_motor_mixer.sv */
`timescale 1ns / 1ps

// motor mixer with desaturation
// req_chan carries one command transaction: thrust, roll, pitch, yaw in signed Q4.12.
// rsp_chan returns NUM_ROTORS transactions per command, rotor 0 first, each with
// rotor_index, the saturated speed_out and last_rotor set on the final rotor.
// csr_* is a write-only register port: min speed at index 0, rotor0..3 mix at 1..4;
// write it only while no command is in flight.
// the first rotor of a command passes command stages 1 to 4, the serializer, rotor
// stage 0, the divider, rotor stages 2 and 3 and the output register; the others
// follow one per cycle while rsp_chan does not stall. the command stages move only
// when the serializer takes a command: a single per-rotor lane (multiply, 13-stage
// divider, thrust multiply) handles the rotors one after another.
// reset clears the configuration registers to zero and empties the pipeline.
// a stalled rsp_chan freezes the rotor lane, the rotor serializer and, once it
// holds a command, the command stages and req_chan.ready; nothing is dropped.
module multirotor_motor_mixer #(
   parameter int NUM_ROTORS = mmm_pkg::NUM_ROTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mmm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   mmm_req_if.sink                         req_chan,
   mmm_rsp_if.source                       rsp_chan
);
   import mmm_pkg::*;

   localparam int CNT_W      = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
   localparam int PROD_W     = 2 * CMD_W;
   localparam int PSUM_W     = PROD_W + 1;
   localparam int MIX_SHIFT  = 14;
   localparam int MIX_HALF   = 8192;
   localparam int KS_W       = MIN_W + 1;
   localparam int TP_W       = WW + CMD_W;
   localparam int THR_SHIFT  = 12;
   localparam int THR_HALF   = 2048;
   localparam int VW         = TP_W - THR_SHIFT + 1;
   localparam int SPEED_MAX  = 32767;
   localparam int SPEED_MIN  = -32768;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [MIN_W-1:0]     spd_min_ff;
   logic [MIX_W-1:0]     mix_ff [MIX_REGS];
   logic [CSR_IDX_W-1:0] mix_sel;

   assign mix_sel = csr_index - REG_ROTOR0_MIX;

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_min_ff <= '0;
         for (int i = 0; i < MIX_REGS; i++) begin
            mix_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_SPD_FLOOR) begin
            spd_min_ff <= csr_wdata[MIN_W-1:0];
         end else if (csr_index >= REG_ROTOR0_MIX && csr_index <= REG_ROTOR3_MIX) begin
            mix_ff[mix_sel[MIX_SEL_W-1:0]] <= csr_wdata[MIX_W-1:0];
         end
      end
   end

   // rotors past the register set use a zero mix with yaw added
   logic [MIX_W-1:0] lane_mix [NUM_ROTORS];
   for (genvar i = 0; i < NUM_ROTORS; i++) begin : g_lane_mix
      if (i < MIX_REGS) begin : g_reg
         assign lane_mix[i] = mix_ff[i];
      end else begin : g_zero
         assign lane_mix[i] = '0;
      end
   end

   // min speed and 1.0 - min speed
   logic signed [WW-1:0]   m_s;
   logic signed [KS_W-1:0] k_s;
   logic                   k_neg;
   logic [KW-1:0]          k_mag;
   logic signed [KS_W-1:0] k_abs;

   assign m_s   = WW'($signed({1'b0, spd_min_ff}));
   assign k_s   = $signed(KS_W'(ONE_Q12)) - $signed({1'b0, spd_min_ff});
   assign k_neg = k_s[KS_W-1];
   assign k_abs = k_neg ? -k_s : k_s;
   assign k_mag = k_abs[KW-1:0];

   // ------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------
   logic out_vld_ff;
   logic ser_vld_ff;
   logic [CNT_W-1:0] ser_cnt_ff;
   logic adv;
   logic ser_last;
   logic ser_take;

   assign adv      = !out_vld_ff || rsp_chan.ready;
   assign ser_last = ser_cnt_ff == CNT_W'(NUM_ROTORS - 1);
   assign ser_take = !ser_vld_ff || (adv && ser_last);
   assign req_chan.ready = ser_take;

   // ------------------------------------------------------------------
   // command stage 1: coefficient products
   // ------------------------------------------------------------------
   logic                     s1_vld_ff;
   logic signed [PROD_W-1:0] s1_roll_ff  [NUM_ROTORS];
   logic signed [PROD_W-1:0] s1_pitch_ff [NUM_ROTORS];
   logic                     s1_ysub_ff  [NUM_ROTORS];
   logic signed [CMD_W-1:0]  s1_thr_ff;
   logic signed [CMD_W-1:0]  s1_yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (ser_take) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         s1_thr_ff <= req_chan.thrust_cmd;
         s1_yaw_ff <= req_chan.yaw_cmd;
         for (int i = 0; i < NUM_ROTORS; i++) begin
            s1_roll_ff[i]  <= req_chan.roll_cmd * $signed(lane_mix[i][15:0]);
            s1_pitch_ff[i] <= req_chan.pitch_cmd * $signed(lane_mix[i][31:16]);
            s1_ysub_ff[i]  <= lane_mix[i][32];
         end
      end
   end

   // ------------------------------------------------------------------
   // command stage 2: round the mix, add thrust and add or subtract yaw
   // ------------------------------------------------------------------
   logic                     s2_vld_ff;
   logic signed [WW-1:0]     s2_w_ff [NUM_ROTORS];
   logic signed [CMD_W-1:0]  s2_thr_ff;
   logic signed [PSUM_W-1:0] mix_sum [NUM_ROTORS];
   logic signed [PSUM_W-1:0] mix_rnd [NUM_ROTORS];
   logic signed [WW-1:0]     w_in    [NUM_ROTORS];

   always_comb begin
      for (int i = 0; i < NUM_ROTORS; i++) begin
         mix_sum[i] = PSUM_W'(s1_roll_ff[i]) + PSUM_W'(s1_pitch_ff[i])
                    + $signed(PSUM_W'(MIX_HALF));
         mix_rnd[i] = mix_sum[i] >>> MIX_SHIFT;
         w_in[i]    = WW'(s1_thr_ff) + WW'(mix_rnd[i])
                    + (s1_ysub_ff[i] ? -WW'(s1_yaw_ff) : WW'(s1_yaw_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (ser_take) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         s2_thr_ff <= s1_thr_ff;
         for (int i = 0; i < NUM_ROTORS; i++) begin
            s2_w_ff[i] <= w_in[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // command stage 3: smallest speed and shortfall below min speed
   // ------------------------------------------------------------------
   logic                    s3_vld_ff;
   logic signed [WW-1:0]    s3_w_ff [NUM_ROTORS];
   logic signed [WW-1:0]    s3_raise_ff;
   logic signed [CMD_W-1:0] s3_thr_ff;
   logic signed [WW-1:0]    wmin;
   logic signed [WW-1:0]    raise_in;

   always_comb begin
      wmin = s2_w_ff[0];
      for (int i = 1; i < NUM_ROTORS; i++) begin
         if (s2_w_ff[i] < wmin) begin
            wmin = s2_w_ff[i];
         end
      end
      raise_in = (wmin < m_s) ? m_s - wmin : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (ser_take) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         s3_thr_ff   <= s2_thr_ff;
         s3_raise_ff <= raise_in;
         for (int i = 0; i < NUM_ROTORS; i++) begin
            s3_w_ff[i] <= s2_w_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // command stage 4: raise all speeds, largest speed
   // ------------------------------------------------------------------
   logic                    s4_vld_ff;
   logic signed [WW-1:0]    s4_w_ff [NUM_ROTORS];
   logic signed [WW-1:0]    s4_wmax_ff;
   logic signed [CMD_W-1:0] s4_thr_ff;
   logic signed [WW-1:0]    wmax;

   always_comb begin
      wmax = s3_w_ff[0];
      for (int i = 1; i < NUM_ROTORS; i++) begin
         if (s3_w_ff[i] > wmax) begin
            wmax = s3_w_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (ser_take) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         s4_thr_ff  <= s3_thr_ff;
         s4_wmax_ff <= wmax + s3_raise_ff;
         for (int i = 0; i < NUM_ROTORS; i++) begin
            s4_w_ff[i] <= s3_w_ff[i] + s3_raise_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // rotor serializer: holds one command; unless stalled, hands out one rotor per cycle
   // ------------------------------------------------------------------
   logic signed [WW-1:0]    ser_w_ff [NUM_ROTORS];
   logic signed [WW-1:0]    ser_span_ff;
   logic                    ser_rescale_ff;
   logic                    ser_zero_ff;
   logic signed [CMD_W-1:0] ser_thr_ff;
   logic signed [WW-1:0]    span_in;

   assign span_in = s4_wmax_ff - m_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= '0;
      end else if (ser_take) begin
         ser_vld_ff <= s4_vld_ff;
         ser_cnt_ff <= '0;
      end else if (adv) begin
         ser_cnt_ff <= ser_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         ser_thr_ff     <= s4_thr_ff;
         ser_span_ff    <= span_in;
         ser_rescale_ff <= s4_wmax_ff > $signed(WW'(ONE_Q12));
         ser_zero_ff    <= span_in == '0;
         for (int i = 0; i < NUM_ROTORS; i++) begin
            ser_w_ff[i] <= s4_w_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // rotor stage 0: offset above min speed times (1.0 - min speed)
   // ------------------------------------------------------------------
   logic                 r0_vld_ff;
   logic [PA_W-1:0]      r0_prod_ff;
   logic [WW-2:0]        r0_den_ff;
   rot_tag_type          r0_tag_ff;
   logic signed [WW-1:0] ser_w_cur;
   logic signed [WW-1:0] ser_t;
   rot_tag_type          ser_tag;

   assign ser_w_cur = ser_w_ff[ser_cnt_ff];
   assign ser_t     = ser_w_cur - m_s;

   always_comb begin
      ser_tag.thr       = ser_thr_ff;
      ser_tag.w         = ser_w_cur;
      ser_tag.idx       = IDX_W'(ser_cnt_ff);
      ser_tag.last      = ser_last;
      ser_tag.rescale   = ser_rescale_ff;
      ser_tag.zero_span = ser_zero_ff;
      ser_tag.k_neg     = k_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_vld_ff <= 1'b0;
      end else if (adv) begin
         r0_vld_ff <= ser_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_prod_ff <= ser_t[WW-2:0] * k_mag;
         r0_den_ff  <= ser_span_ff[WW-2:0];
         r0_tag_ff  <= ser_tag;
      end
   end

   // ------------------------------------------------------------------
   // rescale divide: round to nearest, ties up, on the signed quotient
   // positive numerator: floor((2a + d) / 2d)
   // negative numerator: -floor((2|a| + d - 1) / 2d)
   // ------------------------------------------------------------------
   logic [RW-1:0] div_num;
   logic [DW-1:0] div_den;
   logic          div_vld;
   logic [QW-1:0] div_quo;
   rot_tag_type   div_tag;

   assign div_num = RW'({r0_prod_ff, 1'b0}) + RW'(r0_den_ff) - RW'(r0_tag_ff.k_neg);
   assign div_den = DW'({r0_den_ff, 1'b0});

   mmm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (r0_vld_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_tag    (r0_tag_ff),
      .out_valid (div_vld),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // ------------------------------------------------------------------
   // rotor stage 2: offset above min speed after the optional rescale
   // ------------------------------------------------------------------
   logic                    r2_vld_ff;
   logic signed [WW-1:0]    r2_delta_ff;
   logic signed [CMD_W-1:0] r2_thr_ff;
   logic [IDX_W-1:0]        r2_idx_ff;
   logic                    r2_last_ff;
   logic signed [WW-1:0]    q_s;
   logic signed [WW-1:0]    delta_in;

   assign q_s = WW'($signed({1'b0, div_quo}));

   always_comb begin
      if (!div_tag.rescale) begin
         delta_in = div_tag.w - m_s;
      end else if (div_tag.zero_span) begin
         delta_in = '0;
      end else if (div_tag.k_neg) begin
         delta_in = -q_s;
      end else begin
         delta_in = q_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_vld_ff <= 1'b0;
      end else if (adv) begin
         r2_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_delta_ff <= delta_in;
         r2_thr_ff   <= div_tag.thr;
         r2_idx_ff   <= div_tag.idx;
         r2_last_ff  <= div_tag.last;
      end
   end

   // ------------------------------------------------------------------
   // rotor stage 3: thrust scaling product
   // ------------------------------------------------------------------
   logic                   r3_vld_ff;
   logic signed [TP_W-1:0] r3_prod_ff;
   logic [IDX_W-1:0]       r3_idx_ff;
   logic                   r3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r3_vld_ff <= 1'b0;
      end else if (adv) begin
         r3_vld_ff <= r2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r3_prod_ff <= r2_delta_ff * r2_thr_ff;
         r3_idx_ff  <= r2_idx_ff;
         r3_last_ff <= r2_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register: round, add min speed back, saturate
   // ------------------------------------------------------------------
   logic signed [CMD_W-1:0] out_speed_ff;
   logic [IDX_W-1:0]        out_idx_ff;
   logic                    out_last_ff;
   logic signed [TP_W-1:0]  thr_rnd;
   logic signed [VW-1:0]    v_full;
   logic signed [CMD_W-1:0] speed_in;

   always_comb begin
      thr_rnd = (r3_prod_ff + $signed(TP_W'(THR_HALF))) >>> THR_SHIFT;
      v_full  = VW'(m_s) + VW'(thr_rnd);
      if (v_full > $signed(VW'(SPEED_MAX))) begin
         speed_in = CMD_W'(SPEED_MAX);
      end else if (v_full < $signed(VW'(SPEED_MIN))) begin
         speed_in = CMD_W'(SPEED_MIN);
      end else begin
         speed_in = v_full[CMD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= r3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_speed_ff <= speed_in;
         out_idx_ff   <= r3_idx_ff;
         out_last_ff  <= r3_last_ff;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.speed_out   = out_speed_ff;
   assign rsp_chan.rotor_index = out_idx_ff;
   assign rsp_chan.last_rotor  = out_last_ff;

endmodule

/* src/mmm_checker.sv */
`timescale 1ns / 1ps

module mmm_checker #(
   parameter int NUM_ROTORS = mmm_pkg::NUM_ROTORS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mmm_pkg::IDX_W-1:0]       rotor_index,
   input logic signed [mmm_pkg::CMD_W-1:0] speed_out,
   input logic                            last_rotor
);
   import mmm_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed_out)
         && $stable(rotor_index) && $stable(last_rotor))
      else $error("stalled result changed");

   // last flag marks exactly the final rotor
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_rotor == (rotor_index == IDX_W'(NUM_ROTORS - 1))))
      else $error("last_rotor does not match rotor_index");

   // rotors of one command follow back to back in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_rotor |=>
         rsp_valid && (rotor_index == $past(rotor_index) + 3'd1))
      else $error("rotor sequence broken");

endmodule

bind multirotor_motor_mixer mmm_checker #(.NUM_ROTORS(NUM_ROTORS)) u_mmm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rotor_index (rsp_chan.rotor_index),
   .speed_out   (rsp_chan.speed_out),
   .last_rotor  (rsp_chan.last_rotor)
);

/* sim/multirotor_motor_mixer_tb.sv */
`timescale 1ns / 1ps

module multirotor_motor_mixer_tb;
   import mmm_pkg::*;

   localparam int NR = NUM_ROTORS_DEF;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 70;
   localparam int STALL_CYCLES = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic signed [15:0] QX = 16'sd11585; // 0.7071 in Q1.14

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic signed [15:0]     thr, rol, pit, yaw;
      bit                     typed;
      logic signed [15:0]     speed;
   } dir_row_type;

   typedef struct {
      logic [IDX_W-1:0]    idx;
      logic signed [15:0]  speed;
      logic                last;
   } speed_rec_type;

   typedef struct {
      bit                  typed;
      logic signed [15:0]  speed;
   } cmd_tag_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mmm_req_if req_chan ();
   mmm_rsp_if rsp_chan ();

   multirotor_motor_mixer uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #4 clock = ~clock;

   // shadow copy of the mixer registers
   logic [MIN_W-1:0] mdl_min;
   logic [MIX_W-1:0] mdl_mix [MIX_REGS];

   speed_rec_type speed_q [$];
   cmd_tag_type   tag_q [$];
   dir_row_type   dir_rows [$];

   int errors = 0;
   int cmd_cnt = 0;
   int speed_cnt = 0;
   int sat_cnt = 0;
   int req_acc = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;      // driver asks the receiver for a long hold-off
   bit no_idle = 0;       // stretch with no bubbles on either side

   // ---------------------------------------------------------------
   // fixed-point helpers, nearest rounding with ties upward
   // ---------------------------------------------------------------
   function automatic longint floor_quot(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint near_quot(longint a, longint d);
      return floor_quot(2 * a + d, 2 * d);
   endfunction

   // computes the speed for every rotor and queues them
   function automatic void mix_speeds(logic signed [15:0] thr, logic signed [15:0] rol,
                                      logic signed [15:0] pit, logic signed [15:0] yaw);
      longint w [NR];
      longint m, wmin, wmax, span, v, rc, pc;
      speed_rec_type rec;
      m = longint'(mdl_min);
      for (int i = 0; i < NR; i++) begin
         rc = (i < MIX_REGS) ? longint'($signed(mdl_mix[i][15:0])) : 0;
         pc = (i < MIX_REGS) ? longint'($signed(mdl_mix[i][31:16])) : 0;
         w[i] = thr + near_quot(rol * rc + pit * pc, 16384);
         if (i < MIX_REGS && mdl_mix[i][32]) w[i] -= yaw;
         else w[i] += yaw;
      end
      // lift everything so the slowest rotor reaches min speed
      wmin = w[0];
      for (int i = 1; i < NR; i++) if (w[i] < wmin) wmin = w[i];
      if (wmin < m) for (int i = 0; i < NR; i++) w[i] += m - wmin;
      // squeeze into [min, 1.0] if the fastest rotor overshoots
      wmax = w[0];
      for (int i = 1; i < NR; i++) if (w[i] > wmax) wmax = w[i];
      if (wmax > ONE_Q12) begin
         span = wmax - m;
         for (int i = 0; i < NR; i++)
            w[i] = (span > 0) ? m + near_quot((w[i] - m) * (ONE_Q12 - m), span) : m;
      end
      for (int i = 0; i < NR; i++) begin
         v = m + near_quot((w[i] - m) * thr, ONE_Q12);
         if (v > 32767) begin v = 32767; sat_cnt++; end
         if (v < -32768) begin v = -32768; sat_cnt++; end
         rec.idx = IDX_W'(i);
         rec.speed = v[15:0];
         rec.last = (i == NR - 1);
         speed_q = {speed_q, rec};
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------
   // monitor: accepts on both channels, sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cmd_tag_type tag;
      speed_rec_type exp_rec;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tag = tag_q.pop_front();
            mix_speeds(req_chan.thrust_cmd, req_chan.roll_cmd,
                       req_chan.pitch_cmd, req_chan.yaw_cmd);
            // typed rows override the predicted speed with the hand value
            if (tag.typed)
               for (int i = 0; i < NR; i++)
                  speed_q[speed_q.size() - NR + i].speed = tag.speed;
            req_acc++;
            cmd_cnt++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            speed_cnt++;
            if (speed_q.size() == 0) begin
               report_mismatch("unexpected transaction, rotor_index", rsp_chan.rotor_index, -1);
            end else begin
               exp_rec = speed_q.pop_front();
               if (rsp_chan.rotor_index !== exp_rec.idx)
                  report_mismatch("rotor_index", rsp_chan.rotor_index, exp_rec.idx);
               if (rsp_chan.speed_out !== exp_rec.speed)
                  report_mismatch("speed_out", rsp_chan.speed_out, exp_rec.speed);
               if (rsp_chan.last_rotor !== exp_rec.last)
                  report_mismatch("last_rotor", rsp_chan.last_rotor, exp_rec.last);
            end
         end
         // watchdog on traffic
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d speeds outstanding", speed_q.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------
   initial begin
      rsp_chan.ready = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 0;
            repeat (STALL_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= 10);
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------
   // sender tasks, all called at a falling edge
   // ---------------------------------------------------------------
   task automatic wait_drained();
      while (speed_q.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);   // pipeline latency margin
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic [CSR_IDX_W-1:0] sel;
      req_chan.valid <= 0;
      wait_drained();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      sel = idx - REG_ROTOR0_MIX;
      if (idx == REG_SPD_FLOOR) mdl_min = data[MIN_W-1:0];
      else if (idx <= REG_ROTOR3_MIX) mdl_mix[sel[MIX_SEL_W-1:0]] = data[MIX_W-1:0];
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task automatic send_cmd(logic signed [15:0] thr, logic signed [15:0] rol,
                           logic signed [15:0] pit, logic signed [15:0] yaw,
                           bit typed, logic signed [15:0] speed);
      int seen;
      cmd_tag_type tag;
      if (!no_idle && $urandom_range(99) < 10) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      tag.typed = typed;
      tag.speed = speed;
      tag_q = {tag_q, tag};
      seen = req_acc;
      req_chan.valid <= 1;
      req_chan.thrust_cmd <= thr;
      req_chan.roll_cmd <= rol;
      req_chan.pitch_cmd <= pit;
      req_chan.yaw_cmd <= yaw;
      do @(negedge clock); while (req_acc == seen);
   endtask

   function automatic logic signed [15:0] rand_field(bit thrust);
      case ($urandom_range(7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'($urandom());
         default: return thrust ? 16'($urandom_range(8192))
                                : 16'($urandom_range(12000) - 6000);
      endcase
   endfunction

   function automatic logic [MIX_W-1:0] rand_mix(int rotor);
      logic signed [15:0] r, p;
      if ($urandom_range(1)) begin
         // x-frame layout, sign pattern by rotor
         r = (rotor == 0 || rotor == 3) ? -QX : QX;
         p = (rotor == 0 || rotor == 2) ? QX : -QX;
         return {logic'(rotor[0] ^ rotor[1]), p, r};
      end
      return {logic'($urandom_range(1)), 16'($urandom()), 16'($urandom())};
   endfunction

   function automatic void add_cmd(int thr, int rol, int pit, int yaw,
                                   bit typed = 0, int speed = 0);
      dir_row_type row;
      row.kind = ROW_CMD;
      row.idx = '0; row.data = '0;
      row.thr = 16'(thr); row.rol = 16'(rol); row.pit = 16'(pit); row.yaw = 16'(yaw);
      row.typed = typed; row.speed = 16'(speed);
      dir_rows = {dir_rows, row};
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      dir_row_type row;
      row = '{ROW_CSR, idx, data, 0, 0, 0, 0, 0, 0};
      dir_rows = {dir_rows, row};
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      logic [MIN_W-1:0] min_pick;
      mdl_min = '0;
      for (int i = 0; i < MIX_REGS; i++) mdl_mix[i] = '0;
      req_chan.valid = 0;
      req_chan.thrust_cmd = 0;
      req_chan.roll_cmd = 0;
      req_chan.pitch_cmd = 0;
      req_chan.yaw_cmd = 0;

      // after reset every mix is zero: all rotors get thrust plus yaw
      add_cmd(0, 0, 0, 0, 1, 0);
      add_cmd(4096, 1000, -1000, 0, 1, 4096);
      add_cmd(-32768, 0, 0, 0, 1, 0);          // lifted to min speed zero
      add_cmd(32767, 0, 0, 0, 1, 32767);        // rescaled to 1.0 then times thrust
      add_cmd(2048, 0, 0, -2048, 1, 0);
      // x-frame mix at min speed zero
      add_csr(REG_SPD_FLOOR, 33'd0);
      add_csr(REG_ROTOR0_MIX, {1'b0, QX, -QX});
      add_csr(REG_ROTOR0_MIX + 3'd1, {1'b1, -QX, QX});
      add_csr(REG_ROTOR0_MIX + 3'd2, {1'b1, QX, QX});
      add_csr(REG_ROTOR3_MIX, {1'b0, -QX, -QX});
      add_cmd(2048, 32767, 0, 0);
      add_cmd(2048, 0, -32768, 0);
      add_cmd(2048, 0, 0, 32767);
      add_cmd(2048, 0, 0, -32768);
      add_cmd(0, 500, 500, 500);
      add_cmd(32767, 32767, 32767, 32767);
      // min speed above one, used as given; equal rotors give a zero span
      add_csr(REG_SPD_FLOOR, 33'h1FFF);
      add_cmd(-32768, 100, -100, 0);            // saturates high
      add_cmd(32767, -32768, 32767, -32768);
      add_cmd(4096, 0, 0, 0);
      // min speed at one, widest mix words, ignored register indexes
      add_csr(REG_SPD_FLOOR, 33'd4096);
      add_csr(REG_ROTOR0_MIX + 3'd1, {MIX_W{1'b1}});
      add_csr(3'd5, {MIX_W{1'b1}});
      add_csr(3'd7, 33'h0_0000_1234);
      add_cmd(32767, -32768, -32768, 32767);
      add_cmd(-32768, 32767, 32767, -32768);
      add_cmd(-32768, -32768, -32768, -32768);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR)
            write_reg(dir_rows[r].idx, dir_rows[r].data);
         else
            send_cmd(dir_rows[r].thr, dir_rows[r].rol, dir_rows[r].pit, dir_rows[r].yaw,
                     dir_rows[r].typed, dir_rows[r].speed);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: min_pick = '0;
            1: min_pick = 13'd4096;
            2: min_pick = 13'h1FFF;
            default: min_pick = ($urandom_range(3) == 0) ? MIN_W'($urandom())
                                                         : MIN_W'($urandom_range(1500));
         endcase
         write_reg(REG_SPD_FLOOR, CSR_DATA_W'(min_pick));
         for (int i = 0; i < MIX_REGS; i++)
            write_reg(REG_ROTOR0_MIX + CSR_IDX_W'(i), rand_mix(i));
         no_idle = (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 10) hold_rsp = 1;    // sender keeps offering meanwhile
            if (p == 3 && k == 35) begin
               req_chan.valid <= 0;
               while (speed_q.size() != 0) @(negedge clock);
            end
            send_cmd(rand_field(1), rand_field(0), rand_field(0), rand_field(0), 0, 0);
         end
         no_idle = 0;
      end
      req_chan.valid <= 0;

      while (speed_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d commands, %0d rotor speeds checked, %0d saturated",
               cmd_cnt, speed_cnt, sat_cnt);
      $display("register settings: min speed 0, 1.0, max and random; x-frame and random mixes");
      if (errors == 0 && speed_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
